@@ rtl/bcld_pkg.sv @@
// Shared types, phase codes and register map of the button click and long-press detector.
package bcld_pkg;

   localparam int TIME_BITS = 32;

   localparam int PHASE_BITS = 3;
   localparam int CLICK_BITS = 2;
   localparam int CFG_BITS   = 16;
   localparam int APB_DATA_BITS = 32;
   localparam int APB_ADDR_BITS = 3;

   localparam logic [PHASE_BITS-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_DOWN     = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_UP       = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_COUNT    = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_PRESS    = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_PRESSEND = 3'd5;

   localparam logic [CLICK_BITS-1:0] CLICK_LIMIT = 2'd2;
   localparam logic [CLICK_BITS-1:0] CLICK_MAX   = 2'd3;

   localparam logic REG_PRESS_THRESHOLD = 1'b0;
   localparam logic REG_CLICK_WINDOW    = 1'b1;

   localparam logic [CFG_BITS-1:0] PRESS_THRESHOLD_RESET = 16'd800;
   localparam logic [CFG_BITS-1:0] CLICK_WINDOW_RESET    = 16'd400;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic [CLICK_BITS-1:0] clicks;
      logic [TIME_BITS-1:0]  start;
   } state_type;

   typedef struct packed {
      logic                  click_event;
      logic                  long_press_event;
      logic [PHASE_BITS-1:0] phase;
   } result_type;

endpackage

@@ rtl/bcld_step.sv @@
// Next-state and event logic for one poll tick of the detector.
module bcld_step (
   input  bcld_pkg::state_type              cur,
   input  logic                             active_level,
   input  logic [bcld_pkg::TIME_BITS-1:0]   now,
   input  logic [bcld_pkg::CFG_BITS-1:0]    press_threshold_ms,
   input  logic [bcld_pkg::CFG_BITS-1:0]    click_window_ms,
   output bcld_pkg::state_type              nxt,
   output bcld_pkg::result_type             res
);

   logic [bcld_pkg::TIME_BITS-1:0] elapsed;
   logic [bcld_pkg::TIME_BITS-1:0] threshold_ext;
   logic [bcld_pkg::TIME_BITS-1:0] window_ext;
   logic                           click_ev;
   logic                           long_ev;

   assign elapsed       = now - cur.start;
   assign threshold_ext = bcld_pkg::TIME_BITS'(press_threshold_ms);
   assign window_ext    = bcld_pkg::TIME_BITS'(click_window_ms);

   always_comb begin
      nxt      = cur;
      click_ev = 1'b0;
      long_ev  = 1'b0;
      case (cur.phase)
         bcld_pkg::PH_IDLE: begin
            if (active_level) begin
               nxt.phase  = bcld_pkg::PH_DOWN;
               nxt.start  = now;
               nxt.clicks = '0;
            end
         end
         bcld_pkg::PH_DOWN: begin
            if (!active_level) begin
               nxt.phase = bcld_pkg::PH_UP;
               nxt.start = now;
            end else if (elapsed > threshold_ext) begin
               long_ev   = 1'b1;
               nxt.phase = bcld_pkg::PH_PRESS;
            end
         end
         bcld_pkg::PH_UP: begin
            if (cur.clicks != bcld_pkg::CLICK_MAX) begin
               nxt.clicks = cur.clicks + 2'd1;
            end
            nxt.phase = bcld_pkg::PH_COUNT;
         end
         bcld_pkg::PH_COUNT: begin
            if (active_level) begin
               nxt.phase = bcld_pkg::PH_DOWN;
               nxt.start = now;
            end else if (elapsed >= window_ext || cur.clicks == bcld_pkg::CLICK_LIMIT) begin
               click_ev   = 1'b1;
               nxt.phase  = bcld_pkg::PH_IDLE;
               nxt.clicks = '0;
               nxt.start  = '0;
            end
         end
         bcld_pkg::PH_PRESS: begin
            if (!active_level) begin
               nxt.phase = bcld_pkg::PH_PRESSEND;
               nxt.start = now;
            end
         end
         bcld_pkg::PH_PRESSEND: begin
            nxt.phase  = bcld_pkg::PH_IDLE;
            nxt.clicks = '0;
            nxt.start  = '0;
         end
         default: begin
            nxt.phase = bcld_pkg::PH_IDLE;
         end
      endcase
   end

   assign res.click_event      = click_ev;
   assign res.long_press_event = long_ev;
   assign res.phase            = nxt.phase;

endmodule

@@ rtl/button_click_longpress_detector_top.sv @@
// Top level of the button click and long-press detector: channels, registers, state.
// Usage:
//   req channel: one transaction per poll tick, carrying req_active_level (button
//   pressed, polarity already corrected) and req_now_ms (free-running ms time).
//   rsp channel: exactly one transaction per request, carrying rsp_click_event,
//   rsp_long_press_event and rsp_phase (state after the tick).
//   Configuration over the APB port: press threshold at byte address 0, click
//   window at byte address 4, 16 bits each in pwdata[15:0]; pready is always
//   high. Write only while no transaction is in flight.
//   A request is taken into the input register; once the result register is
//   free, the state update writes its result there and it is offered on rsp.
//   Throughput: one transaction per cycle without stalls; an input register and a
//   result register each hold one transaction, the state update sits between them.
//   When the receiver stalls, the result holds and the input register fills;
//   req_stall then rises until the result is taken, and nothing is dropped.
//   Reset (synchronous, active high) empties both registers, returns the
//   machine to idle with no clicks and start time zero, and loads the default
//   threshold of 800 ms and window of 400 ms.
module button_click_longpress_detector_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_active_level,
   input  logic [31:0]                          req_now_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_click_event,
   output logic                                 rsp_long_press_event,
   output logic [bcld_pkg::PHASE_BITS-1:0]      rsp_phase,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [bcld_pkg::APB_ADDR_BITS-1:0]   paddr,
   input  logic [bcld_pkg::APB_DATA_BITS-1:0]   pwdata,
   output logic [bcld_pkg::APB_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   logic [bcld_pkg::CFG_BITS-1:0]  threshold_ff, threshold_in;
   logic [bcld_pkg::CFG_BITS-1:0]  window_ff, window_in;
   logic                           cfg_write;
   logic                           reg_sel;

   logic                           in_valid_ff, in_valid_in;
   logic                           in_level_ff;
   logic [bcld_pkg::TIME_BITS-1:0] in_now_ff;
   logic                           req_take;

   logic                           out_valid_ff, out_valid_in;
   bcld_pkg::result_type           out_ff;
   logic                           out_free;
   logic                           advance;

   bcld_pkg::state_type            state_ff, state_in;
   bcld_pkg::result_type           step_res;

   // configuration port
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      threshold_in = threshold_ff;
      window_in    = window_ff;
      if (cfg_write) begin
         if (reg_sel == bcld_pkg::REG_PRESS_THRESHOLD) begin
            threshold_in = pwdata[bcld_pkg::CFG_BITS-1:0];
         end else begin
            window_in = pwdata[bcld_pkg::CFG_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == bcld_pkg::REG_CLICK_WINDOW) begin
         prdata = bcld_pkg::APB_DATA_BITS'(window_ff);
      end else begin
         prdata = bcld_pkg::APB_DATA_BITS'(threshold_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= bcld_pkg::PRESS_THRESHOLD_RESET;
         window_ff    <= bcld_pkg::CLICK_WINDOW_RESET;
      end else begin
         threshold_ff <= threshold_in;
         window_ff    <= window_in;
      end
   end

   // flow control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   bcld_step u_step (
      .cur                (state_ff),
      .active_level       (in_level_ff),
      .now                (in_now_ff),
      .press_threshold_ms (threshold_ff),
      .click_window_ms    (window_ff),
      .nxt                (state_in),
      .res                (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.phase  <= bcld_pkg::PH_IDLE;
         state_ff.clicks <= '0;
         state_ff.start  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff <= req_active_level;
         in_now_ff   <= bcld_pkg::TIME_BITS'(req_now_ms);
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_click_event      = out_ff.click_event;
   assign rsp_long_press_event = out_ff.long_press_event;
   assign rsp_phase            = out_ff.phase;

   a_events_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.click_event && out_ff.long_press_event))
      else $error("click and long press in one transaction");

   a_click_to_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.click_event) |-> (out_ff.phase == bcld_pkg::PH_IDLE))
      else $error("click reported outside idle");

   a_long_to_press: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.long_press_event) |-> (out_ff.phase == bcld_pkg::PH_PRESS))
      else $error("long press reported outside pressed phase");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transaction");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("request stalled while a register is free");

endmodule

@@ tb/sv/button_click_longpress_detector_top_tb.sv @@
// Self-checking testbench for the button click and long-press detector top level.
module button_click_longpress_detector_top_tb;

   localparam int unsigned LIMIT_CYCLES   = 600000;
   localparam int unsigned N_SETTINGS     = 10;
   localparam int unsigned TICKS_PER_SET  = 135;
   localparam int unsigned HOLD_OFF_LEN   = 400;

   typedef struct packed {
      logic        level;
      logic [31:0] now;
   } poll_tick_type;

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_active_level = 1'b0;
   logic [31:0]                        req_now_ms = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_click_event;
   logic                               rsp_long_press_event;
   logic [bcld_pkg::PHASE_BITS-1:0]    rsp_phase;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [bcld_pkg::APB_ADDR_BITS-1:0] paddr = '0;
   logic [bcld_pkg::APB_DATA_BITS-1:0] pwdata = '0;
   logic [bcld_pkg::APB_DATA_BITS-1:0] prdata;
   logic                               pready;

   button_click_longpress_detector_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_active_level     (req_active_level),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_click_event      (rsp_click_event),
      .rsp_long_press_event (rsp_long_press_event),
      .rsp_phase            (rsp_phase),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // detector state and registers as the testbench tracks them
   logic [bcld_pkg::PHASE_BITS-1:0] fsm_phase     = bcld_pkg::PH_IDLE;
   logic [bcld_pkg::CLICK_BITS-1:0] fsm_clicks    = '0;
   logic [bcld_pkg::TIME_BITS-1:0]  fsm_start     = '0;
   logic [bcld_pkg::CFG_BITS-1:0]   cfg_threshold = bcld_pkg::PRESS_THRESHOLD_RESET;
   logic [bcld_pkg::CFG_BITS-1:0]   cfg_window    = bcld_pkg::CLICK_WINDOW_RESET;

   poll_tick_type         pending_ticks_q[$];
   bcld_pkg::result_type  expected_results_q[$];
   poll_tick_type         cur_tick;
   bcld_pkg::result_type  exp_res;
   logic [31:0]           t_now = '0;

   int          outstanding = 0;
   int unsigned errors = 0;
   int unsigned ticks_queued = 0;
   int unsigned rsp_seen = 0;
   int unsigned clicks_seen = 0;
   int unsigned longs_seen = 0;
   int unsigned cycles = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned stall_n;
   int unsigned stall_cycles = 0;
   bit          hold_done = 0;
   bit          no_idle = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function bcld_pkg::result_type advance_button_fsm(input poll_tick_type t);
      bcld_pkg::result_type           r;
      logic [bcld_pkg::TIME_BITS-1:0] elapsed;
      r       = '0;
      elapsed = t.now - fsm_start;
      case (fsm_phase)
         bcld_pkg::PH_IDLE: begin
            if (t.level) begin
               fsm_phase  = bcld_pkg::PH_DOWN;
               fsm_start  = t.now;
               fsm_clicks = '0;
            end
         end
         bcld_pkg::PH_DOWN: begin
            if (!t.level) begin
               fsm_phase = bcld_pkg::PH_UP;
               fsm_start = t.now;
            end else if (elapsed > bcld_pkg::TIME_BITS'(cfg_threshold)) begin
               r.long_press_event = 1'b1;
               fsm_phase          = bcld_pkg::PH_PRESS;
            end
         end
         bcld_pkg::PH_UP: begin
            if (fsm_clicks != bcld_pkg::CLICK_MAX)
               fsm_clicks = fsm_clicks + 2'd1;
            fsm_phase = bcld_pkg::PH_COUNT;
         end
         bcld_pkg::PH_COUNT: begin
            if (t.level) begin
               fsm_phase = bcld_pkg::PH_DOWN;
               fsm_start = t.now;
            end else if (elapsed >= bcld_pkg::TIME_BITS'(cfg_window) ||
                         fsm_clicks == bcld_pkg::CLICK_LIMIT) begin
               r.click_event = 1'b1;
               fsm_phase     = bcld_pkg::PH_IDLE;
               fsm_clicks    = '0;
               fsm_start     = '0;
            end
         end
         bcld_pkg::PH_PRESS: begin
            if (!t.level) begin
               fsm_phase = bcld_pkg::PH_PRESSEND;
               fsm_start = t.now;
            end
         end
         bcld_pkg::PH_PRESSEND: begin
            fsm_phase  = bcld_pkg::PH_IDLE;
            fsm_clicks = '0;
            fsm_start  = '0;
         end
         default: fsm_phase = bcld_pkg::PH_IDLE;
      endcase
      r.phase = fsm_phase;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results_q.push_back(advance_button_fsm(cur_tick));
            gap_left = pick_gap();
         end
         if (req_valid && req_stall) begin
            // payload held while stalled
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_ticks_q.size() > 0) begin
            cur_tick = pending_ticks_q.pop_front();
            outstanding++;
            req_valid        <= 1'b1;
            req_active_level <= cur_tick.level;
            req_now_ms       <= cur_tick.now;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            outstanding--;
            if (rsp_click_event)
               clicks_seen++;
            if (rsp_long_press_event)
               longs_seen++;
            if (expected_results_q.size() == 0) begin
               errors++;
               $display("%0t ERROR unexpected transaction: click %0b long %0b phase %0d",
                        $time, rsp_click_event, rsp_long_press_event, rsp_phase);
            end else begin
               exp_res = expected_results_q.pop_front();
               if (rsp_click_event !== exp_res.click_event) begin
                  errors++;
                  $display("%0t ERROR click_event expected %0b actual %0b",
                           $time, exp_res.click_event, rsp_click_event);
               end
               if (rsp_long_press_event !== exp_res.long_press_event) begin
                  errors++;
                  $display("%0t ERROR long_press_event expected %0b actual %0b",
                           $time, exp_res.long_press_event, rsp_long_press_event);
               end
               if (rsp_phase !== exp_res.phase) begin
                  errors++;
                  $display("%0t ERROR phase expected %0d actual %0d",
                           $time, exp_res.phase, rsp_phase);
               end
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_stall)
            stall_cycles++;
         if (!hold_done && rsp_seen >= 300 && pending_ticks_q.size() >= 20) begin
            hold_done = 1;
            hold_left = HOLD_OFF_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_n = pick_gap();
            if (stall_n > 0) begin
               stall_left = stall_n - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("%0t timeout after %0d cycles, %0d transactions outstanding",
                  $time, cycles, outstanding);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic csr_access(input logic wr, input logic idx,
                             input logic [bcld_pkg::CFG_BITS-1:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (!wr && prdata !== {16'h0, val}) begin
         errors++;
         $display("%0t ERROR register %0d read expected %0h actual %0h",
                  $time, idx, {16'h0, val}, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (wr) begin
         if (idx == bcld_pkg::REG_PRESS_THRESHOLD)
            cfg_threshold = val;
         else
            cfg_window = val;
      end
   endtask

   task automatic add_at(input logic level, input logic [31:0] when);
      poll_tick_type t;
      t_now   = when;
      t.level = level;
      t.now   = when;
      pending_ticks_q.push_back(t);
      ticks_queued++;
   endtask

   function automatic logic [31:0] rand_dt(input int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 0;
      if (r < 8)
         return $urandom();
      return $urandom_range(1, span);
   endfunction

   task automatic add_gesture(input int unsigned hspan, input int unsigned gspan);
      int unsigned presses;
      int unsigned r;
      presses = $urandom_range(1, 4);
      r       = $urandom_range(0, 99);
      if (r < 30)
         t_now = $urandom();
      else if (r < 40)
         t_now = 32'hFFFF_FFFF - $urandom_range(0, 3 * hspan);
      repeat (presses) begin
         repeat ($urandom_range(1, 6)) add_at(1'b1, t_now + rand_dt(hspan));
         repeat ($urandom_range(1, 5)) add_at(1'b0, t_now + rand_dt(gspan));
      end
      repeat ($urandom_range(1, 4)) add_at(1'b0, t_now + rand_dt(2 * gspan));
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 3) == 0)
            add_at(1'($urandom_range(0, 1)), $urandom());
         else
            add_at(1'($urandom_range(0, 1)), t_now + $urandom_range(0, 50));
      end
   endtask

   task automatic wait_drained();
      while (pending_ticks_q.size() != 0 || outstanding > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [bcld_pkg::CFG_BITS-1:0] thr_set[N_SETTINGS];
      logic [bcld_pkg::CFG_BITS-1:0] win_set[N_SETTINGS];
      int unsigned                   base;
      thr_set = '{16'd800, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1,
                  16'($urandom_range(0, 2000)), 16'($urandom_range(0, 300)),
                  16'($urandom_range(0, 65535)), 16'd800};
      win_set = '{16'd400, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1,
                  16'($urandom_range(0, 2000)), 16'($urandom_range(0, 300)),
                  16'($urandom_range(0, 65535)), 16'd400};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int s = 0; s < N_SETTINGS; s++) begin
         if (s > 0) begin
            wait_drained();
            csr_access(1'b1, bcld_pkg::REG_PRESS_THRESHOLD, thr_set[s]);
            csr_access(1'b1, bcld_pkg::REG_CLICK_WINDOW, win_set[s]);
         end
         csr_access(1'b0, bcld_pkg::REG_PRESS_THRESHOLD, cfg_threshold);
         csr_access(1'b0, bcld_pkg::REG_CLICK_WINDOW, cfg_window);
         no_idle = (s % 4 == 3);
         if (s == 0) begin
            // long press held across the time wrap, threshold boundary
            add_at(1'b0, 32'h0000_0000);
            add_at(1'b1, 32'hFFFF_FCE0);
            add_at(1'b1, 32'hFFFF_FFFF);
            add_at(1'b1, 32'h0000_0000);
            add_at(1'b1, 32'h0000_0001);
            add_at(1'b1, 32'd5000);
            add_at(1'b0, 32'd5001);
            add_at(1'b0, 32'd5002);
            // double click ends counting at once
            add_at(1'b1, 32'd6000);
            add_at(1'b0, 32'd6010);
            add_at(1'b0, 32'd6011);
            add_at(1'b1, 32'd6012);
            add_at(1'b0, 32'd6020);
            add_at(1'b0, 32'd6021);
            add_at(1'b0, 32'd6022);
            // third click: count saturates, window boundary ends it
            add_at(1'b1, 32'd7000);
            add_at(1'b0, 32'd7001);
            add_at(1'b0, 32'd7002);
            add_at(1'b1, 32'd7003);
            add_at(1'b0, 32'd7004);
            add_at(1'b0, 32'd7005);
            add_at(1'b1, 32'd7006);
            add_at(1'b0, 32'd7007);
            add_at(1'b0, 32'd7008);
            add_at(1'b0, 32'd7406);
            add_at(1'b0, 32'd7407);
         end
         base = ticks_queued;
         while (ticks_queued - base < TICKS_PER_SET) begin
            if ($urandom_range(0, 99) < 80)
               add_gesture(cfg_threshold / 4 + 2, cfg_window / 4 + 2);
            else
               add_noise();
         end
      end
      wait_drained();
      repeat (6) @(posedge clock);
      if (expected_results_q.size() != 0) begin
         errors++;
         $display("%0t ERROR %0d expected transactions never arrived",
                  $time, expected_results_q.size());
      end
      $display("Run covered %0d poll ticks under %0d register settings:",
               ticks_queued, N_SETTINGS);
      $display("  %0d clicks, %0d long presses; receiver stalled %0d of %0d cycles.",
               clicks_seen, longs_seen, stall_cycles, cycles);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bcld_pkg.sv
rtl/bcld_step.sv
rtl/button_click_longpress_detector_top.sv
tb/sv/button_click_longpress_detector_top_tb.sv
